// ===== src/svalu_pkg.sv =====
// Package with the constants, payload types and helpers of the saturating vector ALU.
`timescale 1ns / 1ps
package svalu_pkg;

  localparam int DATA_BITS = 16;
  localparam int LANES = 8;
  localparam int FRAC_BITS = 8;
  localparam int WORD_BITS = 128;
  localparam int DVD_BITS = DATA_BITS + FRAC_BITS;
  localparam int DIV_STEPS = DVD_BITS;
  localparam int SIX_RAW = 6 * (2 ** FRAC_BITS);
  localparam int LANE_MAX = (2 ** (DATA_BITS - 1)) - 1;
  localparam logic signed [DATA_BITS-1:0] SIX =
      (SIX_RAW > LANE_MAX) ? DATA_BITS'(LANE_MAX) : DATA_BITS'(SIX_RAW);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_RELU = 3'd4;
  localparam logic [2:0] OP_CLAMP6 = 3'd5;

  localparam logic [1:0] ACT_POS = 2'd1;
  localparam logic [1:0] ACT_CLAMP6 = 2'd2;

  localparam logic CFG_OPERATION = 1'b0;
  localparam logic CFG_ACTIVATION = 1'b1;

  typedef struct packed {
    logic [63:0] a_word_low;
    logic [63:0] a_word_high;
    logic [63:0] b_word_low;
    logic [63:0] b_word_high;
    logic        last_word;
  } in_t;

  typedef struct packed {
    logic [63:0] c_word_low;
    logic [63:0] c_word_high;
    logic        last_out;
  } out_t;

  typedef struct packed {
    in_t        data;
    logic [2:0] op;
    logic [1:0] act;
  } item_t;

  function automatic logic signed [DATA_BITS-1:0] relu6(input logic signed [DATA_BITS-1:0] v);
    logic signed [DATA_BITS-1:0] r;
    if (v < 0) r = '0;
    else if (v > SIX) r = SIX;
    else r = v;
    return r;
  endfunction

endpackage

// ===== src/svalu_queue.sv =====
// Short item queue between the front and the back of the ALU.
`timescale 1ns / 1ps
module svalu_queue import svalu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  item_t mem_q [4];

  assign full_o = cnt_q[2];
  assign valid_o = (cnt_q != 3'd0);
  assign item_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= wr_q + 2'd1;
      if (pop_i && valid_o) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'((push_i && !full_o)) - 3'((pop_i && valid_o));
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= item_i;
  end

endmodule

// ===== src/svalu_front.sv =====
// Front end: configuration registers and tagging of accepted words.
`timescale 1ns / 1ps
module svalu_front import svalu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [2:0] cfg_data_i,
  input  in_t        in_i,
  output item_t      item_o
);

  logic [2:0] op_q;
  logic [1:0] act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '0;
      act_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_OPERATION) op_q <= cfg_data_i;
      if (cfg_idx_i == CFG_ACTIVATION) act_q <= cfg_data_i[1:0];
    end
  end

  assign item_o = '{data: in_i, op: op_q, act: act_q};

endmodule

// ===== src/svalu_back.sv =====
// Back end: lane arithmetic with a bit-per-stage divider and a result buffer.
`timescale 1ns / 1ps
module svalu_back import svalu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  take_o,
  output logic  empty_o,
  input  logic  pop_i,
  output out_t  result_o
);

  typedef struct packed {
    logic [DATA_BITS-1:0] res;
    logic                 neg;
    logic                 dz;
    logic [DATA_BITS-1:0] dvs;
    logic [DATA_BITS-1:0] rem;
    logic [DVD_BITS-1:0]  dvd;
    logic [DVD_BITS-1:0]  quo;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lanes;
    logic              is_div;
    logic [1:0]        act;
    logic              last;
  } stage_t;

  function automatic logic signed [DATA_BITS-1:0] sat17(input logic signed [DATA_BITS:0] v);
    logic signed [DATA_BITS-1:0] r;
    if (v[DATA_BITS] != v[DATA_BITS-1]) r = v[DATA_BITS] ? {1'b1, {(DATA_BITS-1){1'b0}}}
                                                        : {1'b0, {(DATA_BITS-1){1'b1}}};
    else r = v[DATA_BITS-1:0];
    return r;
  endfunction

  function automatic stage_t div_step(input stage_t s);
    stage_t o;
    logic [DATA_BITS:0] rn;
    o = s;
    for (int l = 0; l < LANES; l++) begin
      rn = {s.lanes[l].rem, s.lanes[l].dvd[DVD_BITS-1]};
      o.lanes[l].dvd = {s.lanes[l].dvd[DVD_BITS-2:0], 1'b0};
      if (rn >= {1'b0, s.lanes[l].dvs}) begin
        o.lanes[l].rem = DATA_BITS'(rn - {1'b0, s.lanes[l].dvs});
        o.lanes[l].quo = {s.lanes[l].quo[DVD_BITS-2:0], 1'b1};
      end else begin
        o.lanes[l].rem = rn[DATA_BITS-1:0];
        o.lanes[l].quo = {s.lanes[l].quo[DVD_BITS-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  stage_t st_q [DIV_STEPS+1];
  logic [DIV_STEPS:0] v_q;
  stage_t s0_d;
  logic en;

  out_t ob_q [2];
  logic ob_rd_q, ob_wr_q;
  logic [1:0] ob_cnt_q;
  logic ob_full, ob_push;
  out_t fin;

  always_comb begin
    logic signed [DATA_BITS-1:0] a, b, r;
    logic signed [2*DATA_BITS-1:0] p;
    logic signed [2*DATA_BITS-FRAC_BITS-1:0] ps;
    logic [WORD_BITS-1:0] aw, bw;
    aw = {item_i.data.a_word_high, item_i.data.a_word_low};
    bw = {item_i.data.b_word_high, item_i.data.b_word_low};
    s0_d = '0;
    s0_d.is_div = (item_i.op == OP_DIV);
    s0_d.act = item_i.act;
    s0_d.last = item_i.data.last_word;
    for (int l = 0; l < LANES; l++) begin
      a = aw[l*DATA_BITS +: DATA_BITS];
      b = bw[l*DATA_BITS +: DATA_BITS];
      p = a * b;
      ps = p[2*DATA_BITS-1:FRAC_BITS];
      case (item_i.op)
        OP_ADD: r = sat17((DATA_BITS+1)'(a) + (DATA_BITS+1)'(b));
        OP_SUB: r = sat17((DATA_BITS+1)'(a) - (DATA_BITS+1)'(b));
        OP_MUL: begin
          if (ps > LANE_MAX) r = DATA_BITS'(LANE_MAX);
          else if (ps < -LANE_MAX - 1) r = DATA_BITS'(-LANE_MAX - 1);
          else r = ps[DATA_BITS-1:0];
        end
        OP_RELU: r = (a < 0) ? '0 : a;
        OP_CLAMP6: r = relu6(a);
        default: r = a;
      endcase
      s0_d.lanes[l].res = r;
      s0_d.lanes[l].neg = a[DATA_BITS-1] ^ b[DATA_BITS-1];
      s0_d.lanes[l].dz = (b == 0);
      s0_d.lanes[l].dvs = b[DATA_BITS-1] ? DATA_BITS'(-b) : DATA_BITS'(b);
      s0_d.lanes[l].dvd = a[DATA_BITS-1] ? DVD_BITS'(-(DVD_BITS'(signed'(a)) <<< FRAC_BITS))
                                         : DVD_BITS'(DVD_BITS'(signed'(a)) <<< FRAC_BITS);
    end
  end

  always_comb begin
    logic signed [DATA_BITS-1:0] r;
    logic [DVD_BITS-1:0] q;
    logic [WORD_BITS-1:0] w;
    stage_t s;
    s = st_q[DIV_STEPS];
    w = '0;
    for (int l = 0; l < LANES; l++) begin
      q = s.lanes[l].quo;
      if (!s.is_div) r = s.lanes[l].res;
      else if (s.lanes[l].dz) r = '0;
      else if (s.lanes[l].neg) r = (q > DVD_BITS'(LANE_MAX + 1)) ? DATA_BITS'(-LANE_MAX - 1)
                                                                 : DATA_BITS'(-q);
      else r = (q > DVD_BITS'(LANE_MAX)) ? DATA_BITS'(LANE_MAX) : q[DATA_BITS-1:0];
      if (s.act == ACT_POS) r = (r < 0) ? '0 : r;
      else if (s.act == ACT_CLAMP6) r = relu6(r);
      w[l*DATA_BITS +: DATA_BITS] = r;
    end
    fin = '{c_word_low: w[63:0], c_word_high: w[127:64], last_out: s.last};
  end

  assign ob_full = ob_cnt_q[1];
  assign en = !v_q[DIV_STEPS] || !ob_full;
  assign ob_push = en && v_q[DIV_STEPS];
  assign take_o = en;
  assign empty_o = (ob_cnt_q == 2'd0);
  assign result_o = ob_q[ob_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      ob_rd_q <= 1'b0;
      ob_wr_q <= 1'b0;
      ob_cnt_q <= '0;
    end else begin
      if (en) v_q <= {v_q[DIV_STEPS-1:0], valid_i};
      if (ob_push) ob_wr_q <= !ob_wr_q;
      if (pop_i && !empty_o) ob_rd_q <= !ob_rd_q;
      ob_cnt_q <= ob_cnt_q + 2'(ob_push) - 2'((pop_i && !empty_o));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= s0_d;
      for (int k = 1; k <= DIV_STEPS; k++) st_q[k] <= div_step(st_q[k-1]);
    end
    if (ob_push) ob_q[ob_wr_q] <= fin;
  end

endmodule

// ===== src/saturating_vector_alu_with_activation.sv =====
// Top level of the saturating fixed-point vector ALU with fused activation.
//
//   channel  | handshake          | payload
//   input    | push, full         | in_i (out of svalu_pkg::in_t)
//   result   | pop, empty         | result_o (svalu_pkg::out_t)
//   config   | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// One word is taken per cycle while full is low; each word passes in order through
// the input queue, the entry stage, the 24 one-bit stages of the lane dividers and
// the result buffer, each a register, before its result can be popped.
// Reset clears the configuration to add with no activation and empties all queues.
// A stalled result side fills the two-entry result buffer, stalls the pipeline,
// then fills the four-entry input queue, after which full is raised.
`timescale 1ns / 1ps
module saturating_vector_alu_with_activation import svalu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  in_t        in_i,
  output logic       empty,
  input  logic       pop,
  output out_t       result_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [2:0] cfg_data_i
);

  item_t fr_item, q_item;
  logic q_valid, take;

  svalu_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_i, .item_o(fr_item)
  );

  svalu_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .item_i(fr_item), .full_o(full),
    .pop_i(take), .valid_o(q_valid), .item_o(q_item)
  );

  svalu_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .item_i(q_item), .take_o(take),
    .empty_o(empty), .pop_i(pop), .result_o
  );

endmodule

// ===== src/svalu_checker.sv =====
// Port-level checker for the saturating vector ALU, bound to the top level.
`timescale 1ns / 1ps
module svalu_checker import svalu_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic full,
  input logic empty,
  input logic pop,
  input out_t result_o
);

  a_reset_clear: assert property (@(posedge clk_i) !rst_ni |-> empty && !full)
    else $error("queues not empty in reset");

  a_start_open: assert property (@(posedge clk_i) $rose(rst_ni) |-> !full)
    else $error("input blocked after reset");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("waiting result dropped");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(result_o))
    else $error("waiting result changed");

endmodule

bind saturating_vector_alu_with_activation svalu_checker u_checker (
  .clk_i, .rst_ni, .full, .empty, .pop, .result_o
);

// ===== bench/tb.sv =====
// Self-checking testbench for the saturating vector ALU with fused activation.
`timescale 1ns / 1ps
module tb;
  import svalu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b1;
  logic       push = 1'b0;
  logic       full;
  in_t        in_i = '0;
  logic       empty;
  logic       pop = 1'b0;
  out_t       result_o;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [2:0] cfg_data_i = '0;

  logic [2:0] alu_op = OP_ADD;
  logic [1:0] act_mode = 2'd0;
  bit         idle_on = 1'b1;
  out_t       result_q[$];
  int         errors = 0;
  int         cycles = 0;
  int         words_sent = 0;
  int         words_checked = 0;

  saturating_vector_alu_with_activation DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .in_i(in_i),
    .empty(empty), .pop(pop), .result_o(result_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp_lane(longint v);
    longint hi;
    hi = (longint'(1) <<< (DATA_BITS - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint activate(longint v, logic [1:0] mode);
    if (mode == ACT_POS || mode == ACT_CLAMP6) begin
      if (v < 0) return 0;
      if (mode == ACT_CLAMP6 && v > longint'(SIX)) return longint'(SIX);
    end
    return v;
  endfunction

  function automatic out_t alu_word(in_t d, logic [2:0] op, logic [1:0] act);
    logic [WORD_BITS-1:0] aw, bw, cw;
    longint a, b, r;
    out_t o;
    aw = {d.a_word_high, d.a_word_low};
    bw = {d.b_word_high, d.b_word_low};
    cw = '0;
    for (int l = 0; l < LANES; l++) begin
      if ((l + 1) * DATA_BITS > WORD_BITS) break;
      a = longint'($signed(aw[l*DATA_BITS +: DATA_BITS]));
      b = longint'($signed(bw[l*DATA_BITS +: DATA_BITS]));
      case (op)
        OP_ADD: r = clamp_lane(a + b);
        OP_SUB: r = clamp_lane(a - b);
        OP_MUL: r = clamp_lane((a * b) >>> FRAC_BITS);
        OP_DIV: r = (b == 0) ? 0 : clamp_lane((a * (longint'(1) <<< FRAC_BITS)) / b);
        OP_RELU: r = activate(a, ACT_POS);
        OP_CLAMP6: r = activate(a, ACT_CLAMP6);
        default: r = a;
      endcase
      r = activate(r, act);
      cw[l*DATA_BITS +: DATA_BITS] = r[DATA_BITS-1:0];
    end
    o.c_word_low = cw[63:0];
    o.c_word_high = cw[127:64];
    o.last_out = d.last_word;
    return o;
  endfunction

  function automatic logic [DATA_BITS-1:0] rand_lane();
    case ($urandom_range(3))
      0: return DATA_BITS'($urandom);
      1: return DATA_BITS'($signed($urandom_range(2048)) - 1024);
      2: return DATA_BITS'($signed($urandom_range(8 * 256)) - 4 * 256);
      default: begin
        case ($urandom_range(4))
          0: return {1'b0, {(DATA_BITS-1){1'b1}}};
          1: return {1'b1, {(DATA_BITS-1){1'b0}}};
          2: return '0;
          3: return DATA_BITS'(SIX);
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic in_t rand_item();
    logic [WORD_BITS-1:0] aw, bw;
    in_t d;
    for (int l = 0; l < WORD_BITS / DATA_BITS; l++) begin
      aw[l*DATA_BITS +: DATA_BITS] = rand_lane();
      bw[l*DATA_BITS +: DATA_BITS] = ($urandom_range(9) == 0) ? '0 : rand_lane();
    end
    d.a_word_low = aw[63:0];
    d.a_word_high = aw[127:64];
    d.b_word_low = bw[63:0];
    d.b_word_high = bw[127:64];
    d.last_word = $urandom_range(1);
    return d;
  endfunction

  task automatic send_item(in_t d);
    if (idle_on && $urandom_range(99) < 30) repeat ($urandom_range(4, 1)) @(negedge clk_i);
    push = 1'b1;
    in_i = d;
    do @(posedge clk_i); while (full);
    result_q.push_back(alu_word(d, alu_op, act_mode));
    words_sent++;
    @(negedge clk_i);
    push = 1'b0;
  endtask

  task automatic wait_idle();
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [2:0] value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_OPERATION) alu_op = value;
    else act_mode = value[1:0];
  endtask

  task automatic test_directed();
    logic [DATA_BITS-1:0] pat[3][8];
    in_t d;
    logic [WORD_BITS-1:0] aw, bw;
    pat[0] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0100, 16'h0600, 16'h0601, 16'h7fff};
    pat[1] = '{16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'hff00, 16'h0001, 16'h8000, 16'hffff};
    pat[2] = '{16'h8000, 16'h7fff, 16'h05ff, 16'hfeff, 16'h0080, 16'hff80, 16'h0200, 16'h0000};
    for (int op = 0; op < 8; op++) begin
      wait_idle();
      write_reg(CFG_OPERATION, 3'(op));
      write_reg(CFG_ACTIVATION, 3'(op % 4) | 3'(op[0] << 2));
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 8; l++) begin
          aw[l*16 +: 16] = pat[k][l];
          bw[l*16 +: 16] = pat[(k + 1) % 3][7 - l];
        end
        d = {aw[63:0], aw[127:64], bw[63:0], bw[127:64], k == 2};
        send_item(d);
      end
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 16; ph++) begin
      wait_idle();
      write_reg(CFG_OPERATION, (ph < 8) ? 3'(ph) : 3'($urandom));
      write_reg(CFG_ACTIVATION, (ph < 8) ? 3'(ph / 2) : 3'($urandom));
      idle_on = (ph != 11);
      repeat (106) send_item(rand_item());
    end
    idle_on = 1'b1;
  endtask

  always @(negedge clk_i) begin
    pop <= !idle_on || ($urandom_range(99) >= 30);
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && pop && !empty) begin
      if (result_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = result_q.pop_front();
        words_checked++;
        if (result_o.c_word_low !== want.c_word_low) begin
          $error("c_word_low expected %h got %h", want.c_word_low, result_o.c_word_low);
          errors++;
        end
        if (result_o.c_word_high !== want.c_word_high) begin
          $error("c_word_high expected %h got %h", want.c_word_high, result_o.c_word_high);
          errors++;
        end
        if (result_o.last_out !== want.last_out) begin
          $error("last_out expected %b got %b", want.last_out, result_o.last_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    #1 rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    wait_idle();
    $display("Sent %0d words over all operations and activations, checked %0d results.",
             words_sent, words_checked);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

// ===== files.f =====
src/svalu_pkg.sv
src/svalu_queue.sv
src/svalu_front.sv
src/svalu_back.sv
src/saturating_vector_alu_with_activation.sv
src/svalu_checker.sv
bench/tb.sv
